// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the mouse-to-stick converter modules.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_AT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== hdl/mstc_pkg.sv =====
// Shared types and constants for the mouse-to-stick converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mstc_pkg;

   localparam int DELTA_W  = 16;
   localparam int SENS_W   = 16;
   localparam int WHEEL_W  = 16;
   localparam int NUM_RES  = 5;
   localparam int CNT_W    = 3;

   localparam logic signed [WHEEL_W:0] WHEEL_LIMIT = 17'sd32767;

   localparam logic [7:0] STICK_CENTER = 8'd128;
   localparam logic [7:0] TRIG_OFF     = 8'd0;
   localparam logic [7:0] TRIG_ON      = 8'd255;

   typedef enum logic [1:0] {
      KIND_MOTION = 2'd0,
      KIND_WHEEL  = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_RX   = 2'd0,
      AXIS_RY   = 2'd1,
      AXIS_LTRG = 2'd2,
      AXIS_RTRG = 2'd3
   } axis_type;

   typedef enum logic {
      EV_CONNECT = 1'b0,
      EV_SET_AXIS = 1'b1
   } event_type;

   typedef enum logic {
      CSR_ENABLE      = 1'b0,
      CSR_SENSITIVITY = 1'b1
   } csr_index_type;

   typedef struct packed {
      event_type  event_res;
      axis_type   axis;
      logic [7:0] value;
      logic       last;
   } rsp_entry_type;

endpackage

// ===== hdl/mouse_to_stick_converter.sv =====
// Top level of the mouse-to-stick converter: input register, accumulators, tick logic.
// Depends on mstc_pkg, mstc_stick_map, mstc_rsp_queue and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  Channel  | Dir | Handshake             | Payload
//  ---------+-----+-----------------------+------------------------------------------
//  req      | in  | req_tvalid/req_tready | tuser: kind; tdata: delta_x, delta_y
//  rsp      | out | rsp_tvalid/rsp_tready | tuser: event_res; tdata: axis, value; tlast
//  csr      | in  | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// Motion and wheel beats are taken one per cycle while no tick waits in the input register;
// each lands in the input register and, when enabled, is folded into its accumulator on the
// following cycle. An enabled frame tick leaves the input register only once the result
// queue is empty. Its results are then loaded into the result queue, and a following tick
// waits in the input register until they have drained.
// Reset is synchronous and active high; it restores the register defaults, clears the
// accumulators, trigger pulse and pad-connected flag, and centres the stick history.
// A stall on rsp only backs up the req side once a second tick is waiting.
module mouse_to_stick_converter #(
   parameter int ACC_LIMIT      = 1048576,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] delta_x, [31:16] delta_y
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] axis, [9:2] value, [15:10] zero
   output logic [0:0]  rsp_tuser,   // [0] event_res
   output logic        rsp_tlast,
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import mstc_pkg::*;

   // Accumulator width holds +-ACC_LIMIT; the sum width also covers a full input delta.
   localparam int ACC_W = $clog2(ACC_LIMIT + 1) + 1;
   localparam int SUM_W = ((ACC_W > DELTA_W) ? ACC_W : DELTA_W) + 1;
   localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'(ACC_LIMIT);
   localparam logic signed [SUM_W-1:0] ACC_LO = -SUM_W'(ACC_LIMIT);
   localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(4 * (1 << GAIN_FRAC_BITS));

   // Configuration registers.
   logic               enable_ff;
   logic [SENS_W-1:0]  sens_ff;

   // Input register.
   logic                      in_valid_ff, in_valid_in;
   kind_type                  in_kind_ff;
   logic signed [DELTA_W-1:0] in_dx_ff, in_dy_ff;

   // Converter state.
   logic signed [ACC_W-1:0]   acc_x_ff, acc_x_in;
   logic signed [ACC_W-1:0]   acc_y_ff, acc_y_in;
   logic signed [WHEEL_W-1:0] acc_w_ff, acc_w_in;
   logic [7:0]                prev_x_ff, prev_x_in;
   logic [7:0]                prev_y_ff, prev_y_in;
   logic                      pulse_pending_ff, pulse_pending_in;
   logic                      pulse_right_ff, pulse_right_in;
   logic                      pad_ff, pad_in;

   logic                      req_fire;
   logic                      in_consume;
   logic                      active;
   logic                      tick_fire;
   logic                      q_empty;
   logic                      q_valid;
   rsp_entry_type             q_head;

   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [WHEEL_W:0]   sum_w;
   logic [7:0]                stick_x, stick_y;
   logic                      changed, wheel_nz, wheel_neg;

   rsp_entry_type [5:0]          cand;
   logic [5:0]                   cand_vld;
   rsp_entry_type [NUM_RES-1:0]  list;
   logic [CNT_W-1:0]             list_cnt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         sens_ff   <= SENS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:      enable_ff <= csr_data[0];
            CSR_SENSITIVITY: sens_ff   <= csr_data;
            default:         sens_ff   <= sens_ff;
         endcase
      end
   end

   // The input register is free when empty or when its beat is processed this cycle.
   // Only an enabled tick has to wait, and only for the result queue to drain.
   assign active     = in_valid_ff && enable_ff;
   assign tick_fire  = active && (in_kind_ff == KIND_TICK) && q_empty;
   assign in_consume = in_valid_ff && (!(enable_ff && (in_kind_ff == KIND_TICK)) || q_empty);
   assign req_tready = !in_valid_ff || in_consume;
   assign req_fire   = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !in_consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= kind_type'(req_tuser);
         in_dx_ff   <= req_tdata[15:0];
         in_dy_ff   <= req_tdata[31:16];
      end
   end

   // Stick mapping of the accumulated motion, one unit per axis.
   mstc_stick_map #(
      .ACC_W          (ACC_W),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_map_x (
      .delta (acc_x_ff),
      .gain  (sens_ff),
      .value (stick_x)
   );

   mstc_stick_map #(
      .ACC_W          (ACC_W),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_map_y (
      .delta (acc_y_ff),
      .gain  (sens_ff),
      .value (stick_y)
   );

   assign sum_x = SUM_W'(acc_x_ff) + SUM_W'(in_dx_ff);
   assign sum_y = SUM_W'(acc_y_ff) + SUM_W'(in_dy_ff);
   assign sum_w = (WHEEL_W + 1)'(acc_w_ff) + (WHEEL_W + 1)'(in_dy_ff);

   assign changed   = (stick_x != prev_x_ff) || (stick_y != prev_y_ff);
   assign wheel_nz  = (acc_w_ff != '0);
   assign wheel_neg = acc_w_ff[WHEEL_W-1];

   // Candidate results of a tick in their fixed order. The pad-connect request goes
   // ahead of the stick pair, or ahead of the trigger press when the sticks are unchanged.
   always_comb begin
      cand = '0;
      cand_vld[0] = !pad_ff && changed;
      cand[0].event_res = EV_CONNECT;
      cand[0].axis      = AXIS_RX;
      cand[0].value     = 8'd0;

      cand_vld[1] = changed;
      cand[1].event_res = EV_SET_AXIS;
      cand[1].axis      = AXIS_RX;
      cand[1].value     = stick_x;

      cand_vld[2] = changed;
      cand[2].event_res = EV_SET_AXIS;
      cand[2].axis      = AXIS_RY;
      cand[2].value     = stick_y;

      cand_vld[3] = pulse_pending_ff;
      cand[3].event_res = EV_SET_AXIS;
      cand[3].axis      = pulse_right_ff ? AXIS_RTRG : AXIS_LTRG;
      cand[3].value     = TRIG_OFF;

      cand_vld[4] = !pad_ff && !changed && wheel_nz;
      cand[4].event_res = EV_CONNECT;
      cand[4].axis      = AXIS_RX;
      cand[4].value     = 8'd0;

      cand_vld[5] = wheel_nz;
      cand[5].event_res = EV_SET_AXIS;
      cand[5].axis      = wheel_neg ? AXIS_RTRG : AXIS_LTRG;
      cand[5].value     = TRIG_ON;
   end

   // Pack the valid candidates into consecutive queue slots and flag the final one.
   always_comb begin
      list     = '0;
      list_cnt = '0;
      for (int i = 0; i < 6; i++) begin
         if (cand_vld[i] && (list_cnt < CNT_W'(NUM_RES))) begin
            list[list_cnt] = cand[i];
            list_cnt       = list_cnt + CNT_W'(1);
         end
      end
      for (int j = 0; j < NUM_RES; j++) begin
         list[j].last = (list_cnt != '0) && (CNT_W'(j) == list_cnt - CNT_W'(1));
      end
   end

   // Next state of the accumulators and tick history.
   always_comb begin
      acc_x_in         = acc_x_ff;
      acc_y_in         = acc_y_ff;
      acc_w_in         = acc_w_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      pulse_pending_in = pulse_pending_ff;
      pulse_right_in   = pulse_right_ff;
      pad_in           = pad_ff;
      if (active && in_consume) begin
         case (in_kind_ff)
            KIND_MOTION: begin
               if (sum_x > ACC_HI) begin
                  acc_x_in = ACC_W'(ACC_HI);
               end else if (sum_x < ACC_LO) begin
                  acc_x_in = ACC_W'(ACC_LO);
               end else begin
                  acc_x_in = sum_x[ACC_W-1:0];
               end
               if (sum_y > ACC_HI) begin
                  acc_y_in = ACC_W'(ACC_HI);
               end else if (sum_y < ACC_LO) begin
                  acc_y_in = ACC_W'(ACC_LO);
               end else begin
                  acc_y_in = sum_y[ACC_W-1:0];
               end
            end
            KIND_WHEEL: begin
               if (sum_w > WHEEL_LIMIT) begin
                  acc_w_in = WHEEL_W'(WHEEL_LIMIT);
               end else if (sum_w < -WHEEL_LIMIT) begin
                  acc_w_in = WHEEL_W'(-WHEEL_LIMIT);
               end else begin
                  acc_w_in = sum_w[WHEEL_W-1:0];
               end
            end
            KIND_TICK: begin
               acc_x_in = '0;
               acc_y_in = '0;
               acc_w_in = '0;
               if (changed) begin
                  prev_x_in = stick_x;
                  prev_y_in = stick_y;
               end
               pulse_pending_in = wheel_nz;
               if (wheel_nz) begin
                  pulse_right_in = wheel_neg;
               end
               pad_in = pad_ff || changed || wheel_nz;
            end
            default: begin
               acc_x_in = acc_x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff         <= '0;
         acc_y_ff         <= '0;
         acc_w_ff         <= '0;
         prev_x_ff        <= STICK_CENTER;
         prev_y_ff        <= STICK_CENTER;
         pulse_pending_ff <= 1'b0;
         pulse_right_ff   <= 1'b0;
         pad_ff           <= 1'b0;
      end else begin
         acc_x_ff         <= acc_x_in;
         acc_y_ff         <= acc_y_in;
         acc_w_ff         <= acc_w_in;
         prev_x_ff        <= prev_x_in;
         prev_y_ff        <= prev_y_in;
         pulse_pending_ff <= pulse_pending_in;
         pulse_right_ff   <= pulse_right_in;
         pad_ff           <= pad_in;
      end
   end

   // The tick results wait here until the downstream side takes them.
   mstc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (tick_fire),
      .load_cnt  (list_cnt),
      .load_data (list),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (q_valid),
      .head      (q_head),
      .empty     (q_empty)
   );

   assign rsp_tvalid   = q_valid;
   assign rsp_tdata    = {6'b0, q_head.value, q_head.axis};
   assign rsp_tuser[0] = q_head.event_res;
   assign rsp_tlast    = q_head.last;

   `ASSERT_AT(a_tick_clears, tick_fire |=> (acc_x_ff == '0 && acc_y_ff == '0 && acc_w_ff == '0),
              "accumulators not cleared by a tick")
   `ASSERT_NEVER(a_acc_x_lim, (SUM_W'(acc_x_ff) > ACC_HI) || (SUM_W'(acc_x_ff) < ACC_LO),
                 "horizontal accumulator beyond its limit")
   `ASSERT_NEVER(a_acc_y_lim, (SUM_W'(acc_y_ff) > ACC_HI) || (SUM_W'(acc_y_ff) < ACC_LO),
                 "vertical accumulator beyond its limit")
   `ASSERT_AT(a_pad_sticky, $past(pad_ff) |-> pad_ff, "pad-connected flag dropped")

endmodule

// ===== hdl/mstc_stick_map.sv =====
// Scales one accumulated motion axis by the fixed point gain and maps it to a stick value.
// Depends on mstc_pkg.
`timescale 1ns / 1ps

module mstc_stick_map #(
   parameter int ACC_W          = 22,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic signed [ACC_W-1:0]          delta,
   input  logic [mstc_pkg::SENS_W-1:0]      gain,
   output logic [7:0]                       value
);
   import mstc_pkg::*;

   localparam int PW = ACC_W + SENS_W + 1;
   localparam logic signed [PW-1:0] HI_LIM = PW'(127 * (1 << GAIN_FRAC_BITS));
   localparam logic signed [PW-1:0] LO_LIM = -PW'(128 * (1 << GAIN_FRAC_BITS));
   localparam logic [SENS_W-1:0]    GAIN_DEFAULT = SENS_W'(4 * (1 << GAIN_FRAC_BITS));

   logic [SENS_W-1:0]     gain_eff;
   logic signed [PW-1:0]  prod;
   logic signed [PW-1:0]  quot_floor;
   logic                  round_up;
   logic [7:0]            quot;

   // A zero gain falls back to the default of 4.0.
   assign gain_eff   = (gain == '0) ? GAIN_DEFAULT : gain;
   assign prod       = PW'(delta) * $signed({1'b0, gain_eff});
   assign quot_floor = prod >>> GAIN_FRAC_BITS;
   // Arithmetic shift floors; negative values with a fraction step back toward zero.
   assign round_up   = prod[PW-1] && (prod[GAIN_FRAC_BITS-1:0] != '0);
   assign quot       = quot_floor[7:0] + 8'(round_up);

   always_comb begin
      if (prod > HI_LIM) begin
         value = TRIG_ON;
      end else if (prod < LO_LIM) begin
         value = TRIG_OFF;
      end else begin
         value = quot ^ STICK_CENTER;
      end
   end

endmodule

// ===== hdl/mstc_rsp_queue.sv =====
// Shift queue holding the result beats of one frame tick, head registered at the output.
// Depends on mstc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mstc_rsp_queue (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           load,
   input  logic [mstc_pkg::CNT_W-1:0]                     load_cnt,
   input  mstc_pkg::rsp_entry_type [mstc_pkg::NUM_RES-1:0] load_data,
   input  logic                                           pop,
   output logic                                           out_valid,
   output mstc_pkg::rsp_entry_type                        head,
   output logic                                           empty
);
   import mstc_pkg::*;

   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   rsp_entry_type [NUM_RES-1:0]     ent_ff, ent_in;

   always_comb begin
      cnt_in = cnt_ff;
      ent_in = ent_ff;
      if (load) begin
         cnt_in = load_cnt;
         ent_in = load_data;
      end else if (pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < NUM_RES - 1; i++) begin
            ent_in[i] = ent_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign out_valid = (cnt_ff != '0);
   assign empty     = (cnt_ff == '0);
   assign head      = ent_ff[0];

   `ASSERT_NEVER(a_cnt_range, cnt_ff > CNT_W'(NUM_RES), "result count above capacity")
   `ASSERT_NEVER(a_load_busy, load && (cnt_ff != '0), "tick results loaded over pending ones")
   `ASSERT_AT(a_pop_drops, (pop && !load) |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)),
              "pop did not retire exactly one beat")

endmodule
